>>> hdl/assert_macros.svh
// Assertion macros for the key/value table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define KVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kvt_pkg.sv
// Shared types, codes and defaults for the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int EXT_W    = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic search;
    logic exec;
  } cmd_t;

endpackage

>>> hdl/kvt_ctrl.sv
// Request sequencer: accept, search cycle, execute cycle.
`timescale 1ns / 1ps

module kvt_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  output kvt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_EXEC   = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r == S_SEARCH);
  assign accept = start && !busy;

  always_comb begin
    cmd.load   = accept;
    cmd.search = (state_r == S_SEARCH);
    cmd.exec   = (state_r == S_EXEC);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (accept) begin
          state_nxt = S_SEARCH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/kvt_datapath.sv
// Entry registers, parallel key compare, update logic and result registers.
`timescale 1ns / 1ps

module kvt_datapath #(
  parameter int CAPACITY   = kvt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kvt_pkg::cmd_t                  cmd,
  input  logic [kvt_pkg::OP_W-1:0]       in_operation,
  input  logic [kvt_pkg::FIELD_W-1:0]    in_key,
  input  logic [kvt_pkg::FIELD_W-1:0]    in_value,
  output logic                           out_strobe,
  output logic [kvt_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_hit,
  output logic [kvt_pkg::FIELD_W-1:0]    out_found_value,
  output logic [kvt_pkg::INDEX_W-1:0]    out_match_index,
  output logic [kvt_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_is_empty
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0]   key_store_r   [CAPACITY];
  logic [VALUE_BITS-1:0] value_store_r [CAPACITY];
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;

  kvt_pkg::op_t          req_op_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_val_r;

  logic                  hit_r;
  logic [IDX_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] found_r;

  logic                  srch_hit;
  logic [IDX_W-1:0]      srch_pos;
  logic                  full;
  logic [IDX_W-1:0]      tail_idx;

  logic [kvt_pkg::EXT_W-1:0] key_ext;
  logic [kvt_pkg::EXT_W-1:0] val_ext;
  logic [kvt_pkg::EXT_W-1:0] found_ext;
  logic [kvt_pkg::EXT_W-1:0] index_ext;
  logic [kvt_pkg::EXT_W-1:0] count_ext;

  kvt_pkg::status_t      res_status;
  logic                  res_hit;
  logic [IDX_W-1:0]      res_index;
  logic [VALUE_BITS-1:0] res_found;

  logic                           out_strobe_r;
  logic [kvt_pkg::STATUS_W-1:0]   out_status_r;
  logic                           out_hit_r;
  logic [kvt_pkg::FIELD_W-1:0]    out_found_value_r;
  logic [kvt_pkg::INDEX_W-1:0]    out_match_index_r;
  logic [kvt_pkg::COUNT_W-1:0]    out_entry_count_r;
  logic                           out_is_empty_r;

  assign key_ext  = kvt_pkg::EXT_W'(in_key);
  assign val_ext  = kvt_pkg::EXT_W'(in_value);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign tail_idx = count_r[IDX_W-1:0];

  // hold the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op_r  <= kvt_pkg::op_t'(in_operation);
      req_key_r <= key_ext[KEY_BITS-1:0];
      req_val_r <= val_ext[VALUE_BITS-1:0];
    end
  end

  // first valid match, lowest position wins
  always_comb begin
    srch_hit = 1'b0;
    srch_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_r) && (key_store_r[i] == req_key_r)) begin
        srch_hit = 1'b1;
        srch_pos = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r   <= srch_hit;
      pos_r   <= srch_pos;
      found_r <= value_store_r[srch_pos];
    end
  end

  always_comb begin
    res_status = kvt_pkg::ST_DONE;
    res_hit    = 1'b0;
    res_index  = '0;
    res_found  = '0;
    count_nxt  = count_r;
    case (req_op_r)
      kvt_pkg::OP_INSERT: begin
        if (hit_r) begin
          res_hit   = 1'b1;
          res_index = pos_r;
          res_found = found_r;
        end else if (full) begin
          res_status = kvt_pkg::ST_FULL;
        end else begin
          res_index = tail_idx;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      kvt_pkg::OP_LOOKUP, kvt_pkg::OP_DELETE: begin
        if (hit_r) begin
          res_hit   = 1'b1;
          res_index = pos_r;
          res_found = found_r;
          if (req_op_r == kvt_pkg::OP_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          res_status = kvt_pkg::ST_MISS;
        end
      end
      kvt_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // update entries: overwrite, append or shift down
  always_ff @(posedge clk) begin
    if (cmd.exec && hit_r && (req_op_r == kvt_pkg::OP_INSERT)) begin
      value_store_r[pos_r] <= req_val_r;
    end
    if (cmd.exec && !hit_r && !full && (req_op_r == kvt_pkg::OP_INSERT)) begin
      key_store_r[tail_idx]   <= req_key_r;
      value_store_r[tail_idx] <= req_val_r;
    end
    if (cmd.exec && hit_r && (req_op_r == kvt_pkg::OP_DELETE)) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (IDX_W'(i) >= pos_r) begin
          key_store_r[i]   <= key_store_r[i + 1];
          value_store_r[i] <= value_store_r[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign found_ext = kvt_pkg::EXT_W'(res_found);
  assign index_ext = kvt_pkg::EXT_W'(res_index);
  assign count_ext = kvt_pkg::EXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r      <= res_status;
      out_hit_r         <= res_hit;
      out_found_value_r <= found_ext[kvt_pkg::FIELD_W-1:0];
      out_match_index_r <= index_ext[kvt_pkg::INDEX_W-1:0];
      out_entry_count_r <= count_ext[kvt_pkg::COUNT_W-1:0];
      out_is_empty_r    <= (count_nxt == '0);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_found_value = out_found_value_r;
  assign out_match_index = out_match_index_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;

endmodule

>>> hdl/key_value_table.sv
// Key/value table top level: sequencer plus entry datapath.
//
// Usage:
//   Present in_operation, in_key and in_value with start high; the request
//   is taken at a rising edge where start is high and busy is low.
//   Operations: insert (overwrite or append), lookup, delete with shift-down,
//   clear. Every request gives exactly one result.
//   After the accepting edge the search registers load, then the result
//   register loads at the end of the update step, so out_strobe is high for
//   the following cycle and the result is taken at the rising edge ending it.
//   A new request can be taken in the update step of the one before: the
//   search step compares the key against all entries in parallel, the update
//   step applies the update, and busy is high only during the search step.
//   The result ports hold their value until the next result; the receiver
//   cannot stall and must take each result in its strobe cycle.
//   Reset empties the table by clearing the entry count; entry contents are
//   not cleared and are never matched above the entry count.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module key_value_table #(
  parameter int CAPACITY   = kvt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [kvt_pkg::OP_W-1:0]       in_operation,
  input  logic [kvt_pkg::FIELD_W-1:0]    in_key,
  input  logic [kvt_pkg::FIELD_W-1:0]    in_value,
  output logic                           out_strobe,
  output logic [kvt_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_hit,
  output logic [kvt_pkg::FIELD_W-1:0]    out_found_value,
  output logic [kvt_pkg::INDEX_W-1:0]    out_match_index,
  output logic [kvt_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_is_empty
);

  kvt_pkg::cmd_t cmd;

  kvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  kvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_found_value (out_found_value),
    .out_match_index (out_match_index),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  `KVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not enter search")
  `KVT_ASSERT_NEXT(a_search_one, busy, !busy, "search phase lasted more than one cycle")
  `KVT_ASSERT_NOW(a_strobe_src, out_strobe, $past(busy, 2), "result strobe without a request")
  `KVT_ASSERT_NOW(a_full_nohit, out_strobe && (out_status == kvt_pkg::ST_FULL), !out_hit, "full result reports a hit")

endmodule
